// ===== sv/wa16_pkg.sv =====
// Package with opcodes, unit command types and decode helpers for the 16-bit word ALU.
`timescale 1ns / 1ps
`default_nettype none

package wa16_pkg;

    localparam int unsigned DataWidth = 16;
    localparam int unsigned CountWidth = 4;

    // Opcode words.
    localparam logic [15:0] OP_ADD  = 16'he802;
    localparam logic [15:0] OP_SUB  = 16'he803;
    localparam logic [15:0] OP_MUL  = 16'he804;
    localparam logic [15:0] OP_DIV  = 16'he805;
    localparam logic [15:0] OP_EQ   = 16'he806;
    localparam logic [15:0] OP_NE   = 16'he807;
    localparam logic [15:0] OP_LT   = 16'he808;
    localparam logic [15:0] OP_GT   = 16'he809;
    localparam logic [15:0] OP_LE   = 16'he8a8;
    localparam logic [15:0] OP_GE   = 16'he8a9;
    localparam logic [15:0] OP_LAND = 16'he8aa;
    localparam logic [15:0] OP_LOR  = 16'he8bb;
    localparam logic [15:0] OP_BAND = 16'he80a;
    localparam logic [15:0] OP_BOR  = 16'he80b;
    localparam logic [15:0] OP_SHR  = 16'he80c;
    localparam logic [15:0] OP_SHL  = 16'he80d;
    localparam logic [15:0] OP_MOD  = 16'he80e;
    localparam logic [15:0] OP_POW  = 16'h0fe8;

    // Operation run by the shared multi-cycle unit.
    typedef enum logic [1:0] {
        KIND_MUL = 2'b00,
        KIND_DIV = 2'b01,
        KIND_MOD = 2'b10,
        KIND_POW = 2'b11
    } unit_kind_t;

    // Command from the sequencer to the shared unit.
    typedef struct packed {
        logic                 start;
        unit_kind_t           kind;
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] b;
    } unit_cmd_t;

    // Status from the shared unit back to the sequencer.
    typedef struct packed {
        logic                 done;
        logic [DataWidth-1:0] result;
    } unit_status_t;

    // True for opcodes that need the multi-cycle unit.
    function automatic logic op_is_iter(input logic [15:0] op);
        return (op == OP_MUL) || (op == OP_DIV) || (op == OP_MOD) || (op == OP_POW);
    endfunction

    // Maps a multi-cycle opcode onto the unit's operation kind.
    function automatic unit_kind_t op_kind(input logic [15:0] op);
        unit_kind_t kind;
        case (op)
            OP_DIV:  kind = KIND_DIV;
            OP_MOD:  kind = KIND_MOD;
            OP_POW:  kind = KIND_POW;
            default: kind = KIND_MUL;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wa16_logic_unit.sv =====
// Single-cycle add, subtract, compare, logic and shift operations.
`timescale 1ns / 1ps
`default_nettype none

module wa16_logic_unit (
    input  wire logic [15:0]                  operation,
    input  wire logic [wa16_pkg::DataWidth-1:0] operand_a,
    input  wire logic [wa16_pkg::DataWidth-1:0] operand_b,
    output logic      [wa16_pkg::DataWidth-1:0] result
);
    import wa16_pkg::*;

    logic big_shift;
    logic a_nz;
    logic b_nz;

    assign big_shift = (operand_b >= 16'(DataWidth));
    assign a_nz      = (operand_a != '0);
    assign b_nz      = (operand_b != '0);

    // Opcode select; unknown and multi-cycle opcodes give zero here.
    always_comb begin
        case (operation)
            OP_ADD:  result = operand_a + operand_b;
            OP_SUB:  result = operand_a - operand_b;
            OP_EQ:   result = DataWidth'(operand_a == operand_b);
            OP_NE:   result = DataWidth'(operand_a != operand_b);
            OP_LT:   result = DataWidth'(operand_a < operand_b);
            OP_GT:   result = DataWidth'(operand_a > operand_b);
            OP_LE:   result = DataWidth'(operand_a <= operand_b);
            OP_GE:   result = DataWidth'(operand_a >= operand_b);
            OP_LAND: result = DataWidth'(a_nz && b_nz);
            OP_LOR:  result = DataWidth'(a_nz || b_nz);
            OP_BAND: result = operand_a & operand_b;
            OP_BOR:  result = operand_a | operand_b;
            OP_SHR:  result = big_shift ? '0 : (operand_a >> operand_b[3:0]);
            OP_SHL:  result = big_shift ? '0 : (operand_a << operand_b[3:0]);
            default: result = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/wa16_iter_unit.sv =====
// Shared multi-cycle unit: multiply, restoring divide and square-and-multiply power.
`timescale 1ns / 1ps
`default_nettype none

module wa16_iter_unit (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire wa16_pkg::unit_cmd_t    cmd,
    output wa16_pkg::unit_status_t      status
);
    import wa16_pkg::*;

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    unit_kind_t            kind_reg,  kind_next;
    logic [CountWidth-1:0] cnt_reg,   cnt_next;
    logic [DataWidth-1:0]  x_reg,     x_next;
    logic [DataWidth-1:0]  y_reg,     y_next;
    logic [DataWidth-1:0]  b_reg,     b_next;

    logic [DataWidth-1:0]   mul_rhs;
    logic [DataWidth-1:0]   prod_acc;
    logic [DataWidth-1:0]   prod_sq;
    logic [DataWidth:0]     trial;
    logic [DataWidth-1:0]   trial_diff;
    logic                   q_bit;
    logic                   b_zero;

    // Main multiplier serves plain multiply and the power accumulator.
    // Only the low half of each product is kept, since every result wraps at 16 bits.
    assign mul_rhs  = (kind_reg == KIND_MUL) ? b_reg : y_reg;
    assign prod_acc = x_reg * mul_rhs;
    assign prod_sq  = y_reg * y_reg;

    // One restoring division step: shift in the next dividend bit and try a subtract.
    // When the subtract succeeds the difference is below the divisor, so 16 bits hold it.
    assign trial      = {y_reg, x_reg[DataWidth-1]};
    assign trial_diff = trial[DataWidth-1:0] - b_reg;
    assign q_bit      = (trial >= {1'b0, b_reg});
    assign b_zero     = (b_reg == '0);

    // Step sequencing.
    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        kind_next = kind_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        b_next    = b_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            kind_next = cmd.kind;
            cnt_next  = '0;
            b_next    = cmd.b;
            if (cmd.kind == KIND_POW) begin
                x_next = DataWidth'(1);
                y_next = cmd.a;
            end else begin
                x_next = cmd.a;
                y_next = '0;
            end
        end else if (busy_reg) begin
            case (kind_reg)
                KIND_MUL: begin
                    x_next    = prod_acc;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                KIND_DIV, KIND_MOD: begin
                    y_next   = q_bit ? trial_diff : trial[DataWidth-1:0];
                    x_next   = {x_reg[DataWidth-2:0], q_bit};
                    cnt_next = cnt_reg + CountWidth'(1);
                    if (cnt_reg == CountWidth'(DataWidth - 1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: begin
                    // Power: stop once every exponent bit has been used.
                    if (b_reg == '0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        if (b_reg[0]) begin
                            x_next = prod_acc;
                        end
                        y_next = prod_sq;
                        b_next = b_reg >> 1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        kind_reg <= kind_next;
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        b_reg    <= b_next;
    end

    // Result select; a zero divisor gives zero for divide and modulo.
    always_comb begin
        status.done = done_reg;
        case (kind_reg)
            KIND_DIV: status.result = b_zero ? '0 : x_reg;
            KIND_MOD: status.result = b_zero ? '0 : y_reg;
            default:  status.result = x_reg;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/word_alu_sixteen_bit_unit.sv =====
// Top level of the 16-bit word ALU: handshake, sequencer and output register.
//
//   Channel | Direction | Handshake           | Payload
//   s_      | in        | s_valid / s_ready   | s_operation, s_operand_a, s_operand_b
//   m_      | out       | m_valid / m_ready   | m_result
//
// Single-cycle opcodes register their operands first, then their result goes to the output register.
// Multiply is a single unit step; divide and modulo run the one-bit-per-cycle divider.
// Power runs one square-and-multiply step per bit of the exponent's bit length.
// Reset is synchronous and active low; it empties the output register and idles the sequencer.
// A new transaction is taken as soon as the previous result has moved to the output register,
// so a stalled m_ready blocks input only while a second result is also finished.
`timescale 1ns / 1ps
`default_nettype none

module word_alu_sixteen_bit_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [15:0]                    s_operation,
    input  wire logic [wa16_pkg::DataWidth-1:0] s_operand_a,
    input  wire logic [wa16_pkg::DataWidth-1:0] s_operand_b,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [wa16_pkg::DataWidth-1:0] m_result
);
    import wa16_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [15:0]          op_reg;
    logic [DataWidth-1:0] a_reg;
    logic [DataWidth-1:0] b_reg;
    logic                 iter_reg;
    logic                 m_valid_reg;
    logic [DataWidth-1:0] m_result_reg;

    logic                 accept;
    logic                 slot_free;
    logic                 finish;
    logic [DataWidth-1:0] quick_result;
    logic [DataWidth-1:0] final_result;
    unit_cmd_t            cmd;
    unit_status_t         status;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // Multi-cycle operations start straight from the input transaction.
    assign cmd.start = accept && op_is_iter(s_operation);
    assign cmd.kind  = op_kind(s_operation);
    assign cmd.a     = s_operand_a;
    assign cmd.b     = s_operand_b;

    wa16_iter_unit u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status)
    );

    wa16_logic_unit u_logic (
        .operation (op_reg),
        .operand_a (a_reg),
        .operand_b (b_reg),
        .result    (quick_result)
    );

    assign final_result = iter_reg ? status.result : quick_result;
    assign finish       = (state_reg == ST_RUN) && (!iter_reg || status.done) && slot_free;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RUN;
            ST_RUN:  if (finish) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            op_reg   <= s_operation;
            a_reg    <= s_operand_a;
            b_reg    <= s_operand_b;
            iter_reg <= op_is_iter(s_operation);
        end
        if (finish) begin
            m_result_reg <= final_result;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

`default_nettype wire

// ===== sv/wa16_checker.sv =====
// Port-level checker for the 16-bit word ALU and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wa16_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_result
);

    // A stalled result stays valid and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result))
        else $error("stalled result changed or dropped");

    // Only one transaction is in work at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an operation is in work");

    // A result is delivered at the same edge the sequencer goes idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared while the sequencer stayed busy");

    // Reset empties the output register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind word_alu_sixteen_bit_unit wa16_checker u_wa16_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

`default_nettype wire
